// File: rtl/rtpm_pkg.sv
// rtpm_pkg: shared types, codes and constants for the RGB to pixel mapper.
// Used by every module of the block; no dependencies.
`default_nettype none
package rtpm_pkg;

  localparam int CH_W   = 8;   // width of one colour channel
  localparam int PIX_W  = 32;  // pixel and field mask width
  localparam int CNT_W  = 9;   // palette_count register width
  localparam int ENT_W  = 24;  // packed palette entry: red low, blue high
  localparam int SQ_W   = 16;  // one squared channel difference
  localparam int DIST_W = 18;  // sum of three squares
  localparam int TB_W   = 5;   // position of a mask's top bit
  localparam int REG_W  = 3;   // configuration index width

  localparam logic [DIST_W-1:0] DIST_START = 18'd200000;
  localparam logic [TB_W-1:0]   CH_TOP     = 5'd7;

  // input beat kinds (in_tuser)
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_TRUECOLOR = 3'd0;
  localparam logic [REG_W-1:0] REG_RED_MASK  = 3'd1;
  localparam logic [REG_W-1:0] REG_GRN_MASK  = 3'd2;
  localparam logic [REG_W-1:0] REG_BLU_MASK  = 3'd3;
  localparam logic [REG_W-1:0] REG_PAL_COUNT = 3'd4;
  localparam logic [REG_W-1:0] REG_BLACK     = 3'd5;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [CNT_W-1:0] best_idx;
  } scan_sts_t;

  // highest set bit; zero for an empty mask (the mask then clears the channel)
  function automatic logic [TB_W-1:0] top_bit(input logic [PIX_W-1:0] v);
    logic [TB_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < PIX_W; i++) begin
      if (v[i]) begin
        pos = TB_W'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rgb_to_pixel_mapper.sv
// rgb_to_pixel_mapper: top level, configuration registers, control FSM, output register.
// Instantiates rtpm_palette_ram, rtpm_scan and rtpm_pack; uses rtpm_pkg.
//
// Usage:
//   Input beats on in_*: in_tuser selects a load (0) or a map (1). A load writes
//   one palette entry in the cycle it is taken and gives no result; a load whose
//   entry_index is not below PALETTE_DEPTH is dropped. A map gives one beat on out_*.
//   True-colour map: ST_TC takes the packed pixel, then ST_PUSH loads the output register. Palette map:
//   the scan covers n entries, n the active entry count (palette_count, capped at PALETTE_DEPTH); the scan reads
//   one entry per cycle from the single palette RAM read port. An empty palette
//   skips the scan and returns black_pixel with no_match set through ST_PUSH.
//   in_tready is high only while idle, one item in flight at a time. A result that
//   waits on a stalled receiver sits in the output register and the next item is
//   still taken; a further map result then waits until that beat is taken.
//   The user writes configuration through cfg_we/cfg_index/cfg_wdata only while idle;
//   the block itself does not enforce it. Reset (rst_n low, synchronous) restores register
//   defaults and empties the output; palette contents are undefined until loaded.
`default_nettype none
module rgb_to_pixel_mapper
  import rtpm_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,  // entry_index, red, green, blue
  input  wire logic             in_tuser,  // cmd
  // result channel
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [PIX_W-1:0] out_tdata, // pixel
  output logic                  out_tuser, // no_match
  // configuration
  input  wire logic             cfg_we,
  input  wire logic [REG_W-1:0] cfg_index,
  input  wire logic [PIX_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_TC, ST_SCAN, ST_PUSH} state_t;

  state_t           state_r;
  logic             tc_mode_r;
  logic [PIX_W-1:0] red_mask_r, grn_mask_r, blu_mask_r, black_r;
  logic [CNT_W-1:0] pal_count_r;

  logic [CH_W-1:0]  red_r, green_r, blue_r;
  logic [PIX_W-1:0] res_pix_r;
  logic             res_nm_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_nm_r;
  logic             start_r;

  logic [CH_W-1:0]  in_idx, in_red, in_green, in_blue;
  logic             in_acc;
  logic [CNT_W-1:0] n_eff;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic [PIX_W-1:0] tc_pixel;
  scan_ctl_t        scan_ctl;
  scan_sts_t        scan_sts;

  assign in_idx   = in_tdata[7:0];
  assign in_red   = in_tdata[15:8];
  assign in_green = in_tdata[23:16];
  assign in_blue  = in_tdata[31:24];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign n_eff = (32'(pal_count_r) > 32'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                         : pal_count_r;

  assign wr_en = in_acc && (in_tuser == CMD_LOAD) && (32'(in_idx) < 32'(PALETTE_DEPTH));

  assign scan_ctl.start = start_r;
  assign scan_ctl.n     = n_eff;
  assign scan_ctl.red   = red_r;
  assign scan_ctl.green = green_r;
  assign scan_ctl.blue  = blue_r;

  rtpm_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_idx)),
    .wr_data ({in_blue, in_green, in_red}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rtpm_scan #(
    .AW (AW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .sts     (scan_sts)
  );

  rtpm_pack u_pack (
    .clk       (clk),
    .red_fmask (red_mask_r),
    .grn_fmask (grn_mask_r),
    .blu_fmask (blu_mask_r),
    .red       (red_r),
    .green     (green_r),
    .blue      (blue_r),
    .pixel     (tc_pixel)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_mode_r   <= 1'b0;
      red_mask_r  <= 32'h0000_00FF;
      grn_mask_r  <= 32'h0000_FF00;
      blu_mask_r  <= 32'h00FF_0000;
      pal_count_r <= '0;
      black_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRUECOLOR: tc_mode_r   <= cfg_wdata[0];
        REG_RED_MASK:  red_mask_r  <= cfg_wdata;
        REG_GRN_MASK:  grn_mask_r  <= cfg_wdata;
        REG_BLU_MASK:  blu_mask_r  <= cfg_wdata;
        REG_PAL_COUNT: pal_count_r <= cfg_wdata[CNT_W-1:0];
        REG_BLACK:     black_r     <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // control FSM and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // ST_PUSH handles its own refill of the output register
      if (out_valid_r && out_tready && (state_r != ST_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == CMD_MAP)) begin
            red_r   <= in_red;
            green_r <= in_green;
            blue_r  <= in_blue;
            if (tc_mode_r) begin
              state_r <= ST_TC;
            end else if (n_eff == '0) begin
              res_pix_r <= black_r;
              res_nm_r  <= 1'b1;
              state_r   <= ST_PUSH;
            end else begin
              start_r <= 1'b1;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_TC: begin
          res_pix_r <= tc_pixel;
          res_nm_r  <= 1'b0;
          state_r   <= ST_PUSH;
        end
        ST_SCAN: begin
          if (scan_sts.done) begin
            res_pix_r <= scan_sts.found ? PIX_W'(scan_sts.best_idx) : black_r;
            res_nm_r  <= !scan_sts.found;
            state_r   <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= res_pix_r;
            out_nm_r    <= res_nm_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_nm_r;

endmodule
`default_nettype wire

// File: rtl/rtpm_palette_ram.sv
// rtpm_palette_ram: palette store, one write and one registered read port.
// Depends on rtpm_pkg for the entry width.
`default_nettype none
module rtpm_palette_ram
  import rtpm_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [ENT_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [ENT_W-1:0] rd_data
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rtpm_scan.sv
// rtpm_scan: nearest palette entry search, one entry read per cycle.
// Read, square and compare stages; drives the palette RAM read port. Uses rtpm_pkg.
`default_nettype none
module rtpm_scan
  import rtpm_pkg::*;
#(
  parameter int AW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scan_ctl_t        ctl,
  output logic                  rd_en,
  output logic      [AW-1:0]    rd_addr,
  input  wire logic [ENT_W-1:0] rd_data,
  output scan_sts_t             sts
);

  logic             issuing_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;
  logic [CH_W-1:0]  red_r, green_r, blue_r;

  logic             p1_v_r, p1_last_r;
  logic [CNT_W-1:0] p1_idx_r;

  logic             p2_v_r, p2_last_r;
  logic [CNT_W-1:0] p2_idx_r;
  logic [SQ_W-1:0]  sq_r_r, sq_g_r, sq_b_r;

  logic [DIST_W-1:0] best_r;
  logic [CNT_W-1:0]  best_idx_r;
  logic              found_r;
  logic              done_r;

  logic              last_issue;
  logic [CH_W-1:0]   d_r, d_g, d_b;
  logic [DIST_W-1:0] dist_sum;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign last_issue = (cnt_r == (n_r - CNT_W'(1)));
  assign rd_en      = issuing_r;
  assign rd_addr    = AW'(cnt_r);

  assign d_r = abs_diff(red_r,   rd_data[7:0]);
  assign d_g = abs_diff(green_r, rd_data[15:8]);
  assign d_b = abs_diff(blue_r,  rd_data[23:16]);

  assign dist_sum = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r <= p2_v_r && p2_last_r;
      p1_v_r <= issuing_r;
      p2_v_r <= p1_v_r;
      if (ctl.start) begin
        issuing_r <= 1'b1;
      end else if (issuing_r && last_issue) begin
        issuing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cnt_r   <= '0;
      n_r     <= ctl.n;
      red_r   <= ctl.red;
      green_r <= ctl.green;
      blue_r  <= ctl.blue;
    end else if (issuing_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end

    p1_idx_r  <= cnt_r;
    p1_last_r <= last_issue;

    p2_idx_r  <= p1_idx_r;
    p2_last_r <= p1_last_r;
    sq_r_r    <= d_r * d_r;
    sq_g_r    <= d_g * d_g;
    sq_b_r    <= d_b * d_b;

    // strict less-than keeps the first of equal distances
    if (ctl.start) begin
      best_r     <= DIST_START;
      best_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (p2_v_r && (dist_sum < best_r)) begin
      best_r     <= dist_sum;
      best_idx_r <= p2_idx_r;
      found_r    <= 1'b1;
    end
  end

  assign sts.done     = done_r;
  assign sts.found    = found_r;
  assign sts.best_idx = best_idx_r;

endmodule
`default_nettype wire

// File: rtl/rtpm_pack.sv
// rtpm_pack: true-colour packing of three channels into their mask fields.
// Top-bit positions are registered from the masks. Uses rtpm_pkg.
`default_nettype none
module rtpm_pack
  import rtpm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [PIX_W-1:0] red_fmask,
  input  wire logic [PIX_W-1:0] grn_fmask,
  input  wire logic [PIX_W-1:0] blu_fmask,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  output logic      [PIX_W-1:0] pixel
);

  logic [TB_W-1:0] tb_red_r, tb_grn_r, tb_blu_r;

  // (c << tb) >> 7 lines bit 7 of c up with the mask's top bit
  function automatic logic [PIX_W-1:0] place(input logic [CH_W-1:0]  c,
                                             input logic [TB_W-1:0]  tb,
                                             input logic [PIX_W-1:0] mask);
    logic [PIX_W+CH_W-2:0] w;
    w = (PIX_W+CH_W-1)'(c) << tb;
    return PIX_W'(w >> CH_TOP) & mask;
  endfunction

  always_ff @(posedge clk) begin
    tb_red_r <= top_bit(red_fmask);
    tb_grn_r <= top_bit(grn_fmask);
    tb_blu_r <= top_bit(blu_fmask);
  end

  assign pixel = place(red,   tb_red_r, red_fmask)
               | place(green, tb_grn_r, grn_fmask)
               | place(blue,  tb_blu_r, blu_fmask);

endmodule
`default_nettype wire

// File: rtl/rtpm_checker.sv
// rtpm_checker: port-level assertions for rgb_to_pixel_mapper, bound to the top level.
// Uses rtpm_pkg for the beat kind codes.
`default_nettype none
module rtpm_checker
  import rtpm_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             in_tuser,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [PIX_W-1:0] out_tdata
);

  // reset empties the output and leaves the block ready
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty or input not ready after reset");

  // a map beat occupies the block on the next cycle
  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_MAP) |=> !in_tready)
    else $error("input still ready after a map beat");

  // a load beat never gives a result beat
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("result beat after a load");

  // stalled result beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat dropped or changed");

endmodule

bind rgb_to_pixel_mapper rtpm_checker u_rtpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
